// ===== rtl/jsu_pkg.sv =====
// Shared types and codes for the JSON string unescaper.
`default_nettype none
package jsu_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_NO_QUOTE     = 3'd1;
	localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd2;
	localparam logic [2:0] ERR_BAD_HEX      = 3'd3;
	localparam logic [2:0] ERR_NO_SECOND_U  = 3'd4;
	localparam logic [2:0] ERR_BAD_LOW      = 3'd5;
	localparam logic [2:0] ERR_LONE_LOW     = 3'd6;
	localparam logic [2:0] ERR_UNTERMINATED = 3'd7;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       buffer_end;
	} text_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic [2:0] error_code;
		logic       last_of_run;
	} result_t;

	// All results caused by one input byte: up to four UTF-8 bytes, then at most one status.
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [2:0]      n_data;
		logic            tail_vld;
		logic [1:0]      tail_kind;
		logic [2:0]      tail_err;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

endpackage
`default_nettype wire

// ===== rtl/json_string_unescape_utf8_top.sv =====
// JSON string unescaper top level: front parser, record queue and result drain.
//
// Input channel: one byte of JSON text per transaction (text), taken when
// push is high and full is low. Output channel: one result per transaction
// (result), shown while empty is low and taken when pop is high.
// Each input byte yields zero to five results (up to four UTF-8 bytes and
// one status); last_of_run marks the final result of a byte.
// Each byte's record is registered in the record queue before its results show.
// Throughput: one input byte per cycle while the record queue has room, one
// result per cycle out of the drain while pop is high; bytes that expand into
// several UTF-8 bytes give one result per UTF-8 byte and fill the queue.
// full rises when QueueDepth records are waiting; a stalled receiver
// therefore stalls the input after at most QueueDepth byte records.
// Reset clears the parser to idle (waiting for an opening quote) and
// empties the queue.
`default_nettype none
module json_string_unescape_utf8_top
	import jsu_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	output logic       full,
	input  wire text_t text,
	output logic       empty,
	input  wire logic  pop,
	output result_t    result
);
	rec_t front_rec;
	rec_t head_rec;
	logic front_push;
	logic head_pop;
	logic accept;

	assign accept = push && !full;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.text     (text),
		.rec      (front_rec),
		.rec_push (front_push)
	);

	jsu_fifo #(
		.Width (REC_W),
		.Depth (QueueDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (front_push),
		.din    (front_rec),
		.rd_en  (head_pop),
		.dout   (head_rec),
		.full   (full),
		.empty  (empty)
	);

	jsu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.rec     (head_rec),
		.rec_vld (!empty),
		.pop     (pop),
		.rec_pop (head_pop),
		.result  (result)
	);
endmodule
`default_nettype wire

// ===== rtl/jsu_fifo.sv =====
// Short register queue between the front and back parts.
`default_nettype none
module jsu_fifo
	import jsu_pkg::*;
#(
	parameter int Width = REC_W,
	parameter int Depth = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [Width-1:0] din,
	input  wire logic             rd_en,
	output logic      [Width-1:0] dout,
	output logic                  full,
	output logic                  empty
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

	logic [Depth-1:0][Width-1:0] mem_q;
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_wr, do_rd;

	assign full  = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
			end
			if (do_wr && !do_rd) begin
				count_q <= CntW'(count_q + 1'b1);
			end else if (do_rd && !do_wr) begin
				count_q <= CntW'(count_q - 1'b1);
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/jsu_front.sv =====
// Front part: string and escape parser, \u decoding and UTF-8 encoding into one record.
`default_nettype none
module jsu_front
	import jsu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  accept,
	input  wire text_t text,
	output rec_t       rec,
	output logic       rec_push
);
	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_STR    = 4'd1;
	localparam logic [3:0] PH_ESC    = 4'd2;
	localparam logic [3:0] PH_HEX1   = 4'd3;
	localparam logic [3:0] PH_NEEDBS = 4'd4;
	localparam logic [3:0] PH_NEEDU  = 4'd5;
	localparam logic [3:0] PH_HEX2   = 4'd6;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_LO_N  = 8'h6E;
	localparam logic [7:0] CH_LO_R  = 8'h72;
	localparam logic [7:0] CH_LO_T  = 8'h74;
	localparam logic [7:0] CH_LO_U  = 8'h75;

	localparam logic [5:0] SURR_HI = 6'b110110;
	localparam logic [5:0] SURR_LO = 6'b110111;

	logic [3:0]  phase_q, phase_d;
	logic [15:0] acc_q, acc_d, acc_sh;
	logic [1:0]  cnt_q, cnt_d;
	logic [9:0]  hs_q, hs_d;
	logic [7:0]  c;
	logic        hv_ok;
	logic [3:0]  hv;
	logic [20:0] cp;
	logic        do_enc;
	rec_t        r;

	assign c = text.in_byte;

	always_comb begin
		hv_ok = 1'b1;
		hv    = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			hv = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			hv = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			hv = 4'(c - 8'h37);
		end else begin
			hv_ok = 1'b0;
		end
	end

	assign acc_sh = {acc_q[11:0], hv};

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		hs_d    = hs_q;
		cp      = '0;
		do_enc  = 1'b0;
		r       = '0;
		case (phase_q)
			PH_IDLE: begin
				if (c == CH_QUOTE) begin
					phase_d = PH_STR;
				end else if (c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR) begin
					if (text.buffer_end) begin
						r.tail_vld = 1'b1;
						r.tail_kind = KIND_ERROR;
						r.tail_err = ERR_NO_QUOTE;
					end
				end else begin
					r.tail_vld = 1'b1;
					r.tail_kind = KIND_ERROR;
					r.tail_err = ERR_NO_QUOTE;
				end
			end
			PH_STR: begin
				if (c == CH_QUOTE) begin
					r.tail_vld = 1'b1;
					r.tail_kind = KIND_DONE;
					phase_d = PH_IDLE;
				end else if (c == CH_BSL) begin
					phase_d = PH_ESC;
				end else begin
					r.data[0] = c;
					r.n_data = 3'd1;
				end
			end
			PH_ESC: begin
				phase_d = PH_STR;
				r.n_data = 3'd1;
				case (c)
					CH_QUOTE, CH_BSL, CH_SLASH: r.data[0] = c;
					CH_LO_B: r.data[0] = CH_BS;
					CH_LO_F: r.data[0] = CH_FF;
					CH_LO_N: r.data[0] = CH_LF;
					CH_LO_R: r.data[0] = CH_CR;
					CH_LO_T: r.data[0] = CH_TAB;
					CH_LO_U: begin
						r.n_data = 3'd0;
						acc_d = '0;
						cnt_d = '0;
						phase_d = PH_HEX1;
					end
					default: begin
						r.n_data = 3'd0;
						r.tail_vld = 1'b1;
						r.tail_kind = KIND_ERROR;
						r.tail_err = ERR_BAD_ESCAPE;
						phase_d = PH_IDLE;
					end
				endcase
			end
			PH_HEX1, PH_HEX2: begin
				if (!hv_ok) begin
					r.tail_vld = 1'b1;
					r.tail_kind = KIND_ERROR;
					r.tail_err = ERR_BAD_HEX;
					phase_d = PH_IDLE;
				end else begin
					acc_d = acc_sh;
					cnt_d = 2'(cnt_q + 1'b1);
					if (cnt_q == 2'd3) begin
						if (phase_q == PH_HEX1) begin
							if (acc_sh[15:10] == SURR_HI) begin
								hs_d = acc_sh[9:0];
								phase_d = PH_NEEDBS;
							end else if (acc_sh[15:10] == SURR_LO) begin
								r.tail_vld = 1'b1;
								r.tail_kind = KIND_ERROR;
								r.tail_err = ERR_LONE_LOW;
								phase_d = PH_IDLE;
							end else begin
								cp = {5'd0, acc_sh};
								do_enc = 1'b1;
								phase_d = PH_STR;
							end
						end else begin
							if (acc_sh[15:10] != SURR_LO) begin
								r.tail_vld = 1'b1;
								r.tail_kind = KIND_ERROR;
								r.tail_err = ERR_BAD_LOW;
								phase_d = PH_IDLE;
							end else begin
								cp = 21'h10000 + {1'b0, hs_q, acc_sh[9:0]};
								do_enc = 1'b1;
								phase_d = PH_STR;
							end
						end
					end
				end
			end
			PH_NEEDBS: begin
				if (c == CH_BSL) begin
					phase_d = PH_NEEDU;
				end else begin
					r.tail_vld = 1'b1;
					r.tail_kind = KIND_ERROR;
					r.tail_err = ERR_NO_SECOND_U;
					phase_d = PH_IDLE;
				end
			end
			PH_NEEDU: begin
				if (c == CH_LO_U) begin
					acc_d = '0;
					cnt_d = '0;
					phase_d = PH_HEX2;
				end else begin
					r.tail_vld = 1'b1;
					r.tail_kind = KIND_ERROR;
					r.tail_err = ERR_NO_SECOND_U;
					phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase

		if (do_enc) begin
			if (cp < 21'h80) begin
				r.data[0] = cp[7:0];
				r.n_data = 3'd1;
			end else if (cp < 21'h800) begin
				r.data[0] = {3'b110, cp[10:6]};
				r.data[1] = {2'b10, cp[5:0]};
				r.n_data = 3'd2;
			end else if (cp < 21'h10000) begin
				r.data[0] = {4'b1110, cp[15:12]};
				r.data[1] = {2'b10, cp[11:6]};
				r.data[2] = {2'b10, cp[5:0]};
				r.n_data = 3'd3;
			end else begin
				r.data[0] = {5'b11110, cp[20:18]};
				r.data[1] = {2'b10, cp[17:12]};
				r.data[2] = {2'b10, cp[11:6]};
				r.data[3] = {2'b10, cp[5:0]};
				r.n_data = 3'd4;
			end
		end

		if (text.buffer_end && phase_d != PH_IDLE) begin
			r.tail_vld = 1'b1;
			r.tail_kind = KIND_ERROR;
			r.tail_err = ERR_UNTERMINATED;
			phase_d = PH_IDLE;
		end
	end

	assign rec      = r;
	assign rec_push = accept && (r.tail_vld || r.n_data != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			cnt_q   <= '0;
			hs_q    <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			hs_q    <= hs_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/jsu_back.sv =====
// Back part: walks the head record and hands out one result per transaction.
`default_nettype none
module jsu_back
	import jsu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire rec_t  rec,
	input  wire logic  rec_vld,
	input  wire logic  pop,
	output logic       rec_pop,
	output result_t    result
);
	logic [2:0] idx_q;
	logic [2:0] total;
	logic       is_data;
	logic       is_last;
	logic       fire;

	assign total   = 3'(rec.n_data + {2'd0, rec.tail_vld});
	assign is_data = (idx_q < rec.n_data);
	assign is_last = (idx_q == 3'(total - 3'd1));
	assign fire    = pop && rec_vld;
	assign rec_pop = fire && is_last;

	always_comb begin
		result             = '0;
		result.last_of_run = is_last;
		if (is_data) begin
			result.out_byte = rec.data[idx_q[1:0]];
			result.kind     = KIND_DATA;
		end else begin
			result.kind       = rec.tail_kind;
			result.error_code = rec.tail_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= is_last ? 3'd0 : 3'(idx_q + 1'b1);
		end
	end
endmodule
`default_nettype wire
